### hdl/bfdh_pkg.sv
`default_nettype none

package bfdh_pkg;

    // Field and register widths fixed by the interface
    localparam int BITS_W     = 17;
    localparam int HASH_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int DEF_MAX_BITS      = 65536;
    localparam int DEF_MAX_KEY_BYTES = 64;

    localparam logic [63:0]       FNV_BASIS      = 64'hCBF29CE484222325;
    localparam logic [HASH_W-1:0] HASH_LIMIT     = 5'd30;
    localparam logic [BITS_W-1:0] BIT_COUNT_RST  = 17'd65536;
    localparam logic [HASH_W-1:0] HASH_COUNT_RST = 5'd7;
    localparam logic [BITS_W-1:0] MIN_BITS       = 17'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_COUNT  = 2'd0,
        CFG_HASH_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_byte;
        logic       key_last;
    } in_word_t;

    typedef struct packed {
        logic maybe_present;
        logic key_overflow;
    } out_word_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic load;
        logic pass;
        logic minit;
        logic mod;
        logic idx_rd;
        logic idx_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic ovf_now;
        logic pass_last;
        logic mod_last;
        logic idx_last;
        logic miss;
    } status_t;

    // One FNV-1a round: xor the byte in, multiply by 2^40 + 0x1B3 as shift-adds
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

### hdl/bfdh_ctrl.sv
`default_nettype none

module bfdh_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            key_last,
    input  wire bfdh_pkg::status_t status,
    output bfdh_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_PASS  = 9'b000001000,
        S_MINIT = 9'b000010000,
        S_MOD   = 9'b000100000,
        S_RD    = 9'b001000000,
        S_WR    = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.take = 1'b1;
                    if (key_last)
                    begin
                        state_next = status.ovf_now ? S_DONE : S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_PASS;
            end
            S_PASS:
            begin
                cmd.pass = 1'b1;
                if (status.pass_last)
                begin
                    state_next = S_MINIT;
                end
            end
            S_MINIT:
            begin
                cmd.minit  = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.idx_rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.idx_wr = 1'b1;
                if (status.miss || status.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

### hdl/bfdh_dp.sv
`default_nettype none

module bfdh_dp #(
    parameter int MAX_BITS      = bfdh_pkg::DEF_MAX_BITS,
    parameter int MAX_KEY_BYTES = bfdh_pkg::DEF_MAX_KEY_BYTES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bfdh_pkg::in_word_t              in_word,
    input  wire logic                            cfg_we,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire bfdh_pkg::cmd_t                  cmd,
    output bfdh_pkg::status_t                    status,
    output bfdh_pkg::out_word_t                  result
);

    localparam int FILTER_BYTES = (MAX_BITS + 7) / 8;
    localparam int FB_AW        = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
    localparam int KA_W         = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int LEN_W        = $clog2(MAX_KEY_BYTES + 1);
    localparam int NB_W         = bfdh_pkg::BITS_W;
    localparam int HW           = bfdh_pkg::HASH_W;
    localparam logic [6:0] MOD_STEPS_M1 = 7'd64;

    // Configuration
    logic [NB_W-1:0] bit_count_reg;
    logic [HW-1:0]   hash_count_reg;

    // Key assembly
    logic [LEN_W-1:0] key_len_reg;
    logic             ovf_seen_reg;
    logic [63:0]      h1_reg;
    logic             op_reg;

    // Key end work
    logic [63:0]      h2_reg;
    logic [NB_W-1:0]  nb_reg;
    logic [HW-1:0]    k_reg;
    logic [LEN_W-1:0] fcnt_reg;
    logic [LEN_W-1:0] rd_ptr_reg;
    logic [6:0]       mod_cnt_reg;
    logic [64:0]      sh1_reg;
    logic [64:0]      sh2_reg;
    logic [NB_W-1:0]  r1_reg;
    logic [NB_W-1:0]  r2_reg;
    logic [NB_W-1:0]  rw_reg;
    logic [63:0]      acc_reg;
    logic             cy_reg;
    logic [HW-1:0]    idx_cnt_reg;
    logic             pres_reg;
    logic             ovfr_reg;
    logic [FB_AW-1:0] clr_ptr_reg;

    // Memories
    logic [7:0] key_mem [MAX_KEY_BYTES];
    logic [7:0] key_q_reg;
    logic [7:0] filt_mem [FILTER_BYTES];
    logic [7:0] filt_q_reg;

    logic [NB_W-1:0]  nb_eff;
    logic [HW-1:0]    k_eff;
    logic             ovf_now;
    logic [KA_W-1:0]  key_rd_addr;
    logic [FB_AW-1:0] f_addr;
    logic [7:0]       bit_mask;
    logic             bit_hit;
    logic [NB_W-1:0]  r_step;
    logic [64:0]      acc_sum;

    function automatic logic [NB_W-1:0] mod_step(input logic [NB_W-1:0] r, input logic b,
                                                 input logic [NB_W-1:0] nb);
        logic [NB_W:0] t;
        t = {r, b};
        if (t >= {1'b0, nb})
        begin
            t = t - {1'b0, nb};
        end
        return t[NB_W-1:0];
    endfunction

    // Clamp registers into their working ranges
    always_comb
    begin
        if (bit_count_reg < bfdh_pkg::MIN_BITS)
        begin
            nb_eff = bfdh_pkg::MIN_BITS;
        end
        else if (32'(bit_count_reg) > 32'(MAX_BITS))
        begin
            nb_eff = NB_W'(MAX_BITS);
        end
        else
        begin
            nb_eff = bit_count_reg;
        end
        if (hash_count_reg == '0)
        begin
            k_eff = HW'(1);
        end
        else if (hash_count_reg > bfdh_pkg::HASH_LIMIT)
        begin
            k_eff = bfdh_pkg::HASH_LIMIT;
        end
        else
        begin
            k_eff = hash_count_reg;
        end
    end

    // Next index residue: (r + h2 mod nb - carry * 2^64 mod nb) mod nb
    always_comb
    begin
        logic [NB_W:0] t;
        t = {1'b0, r1_reg} + {1'b0, r2_reg};
        if (t >= {1'b0, nb_reg})
        begin
            t = t - {1'b0, nb_reg};
        end
        if (cy_reg)
        begin
            if (t[NB_W-1:0] >= rw_reg)
            begin
                t = t - {1'b0, rw_reg};
            end
            else
            begin
                t = t + {1'b0, nb_reg} - {1'b0, rw_reg};
            end
        end
        r_step = t[NB_W-1:0];
    end

    assign ovf_now     = ovf_seen_reg || (key_len_reg == LEN_W'(MAX_KEY_BYTES));
    assign key_rd_addr = cmd.load ? '0 : rd_ptr_reg[KA_W-1:0];
    assign f_addr      = FB_AW'(r1_reg >> 3);
    assign bit_mask    = 8'd1 << r1_reg[2:0];
    assign bit_hit     = (filt_q_reg & bit_mask) != 8'd0;
    assign acc_sum     = {1'b0, acc_reg} + {1'b0, h2_reg};

    always_comb
    begin
        status.clr_last  = (clr_ptr_reg == FB_AW'(FILTER_BYTES - 1));
        status.ovf_now   = ovf_now;
        status.pass_last = (LEN_W'(fcnt_reg + 1'b1) == key_len_reg);
        status.mod_last  = (mod_cnt_reg == MOD_STEPS_M1);
        status.idx_last  = (HW'(idx_cnt_reg + 1'b1) == k_reg);
        status.miss      = op_reg && !bit_hit;
    end

    assign result.maybe_present = pres_reg;
    assign result.key_overflow  = ovfr_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= bfdh_pkg::BIT_COUNT_RST;
            hash_count_reg <= bfdh_pkg::HASH_COUNT_RST;
            key_len_reg    <= '0;
            ovf_seen_reg   <= 1'b0;
            h1_reg         <= bfdh_pkg::FNV_BASIS;
            clr_ptr_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bfdh_pkg::CFG_BIT_COUNT:  bit_count_reg  <= cfg_data[NB_W-1:0];
                    bfdh_pkg::CFG_HASH_COUNT: hash_count_reg <= cfg_data[HW-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_ptr_reg <= FB_AW'(clr_ptr_reg + 1'b1);
            end
            if (cmd.finish || (cmd.take && in_word.key_last && ovf_now))
            begin
                key_len_reg  <= '0;
                ovf_seen_reg <= 1'b0;
                h1_reg       <= bfdh_pkg::FNV_BASIS;
            end
            else if (cmd.take)
            begin
                if (ovf_now)
                begin
                    ovf_seen_reg <= 1'b1;
                end
                else
                begin
                    key_len_reg <= LEN_W'(key_len_reg + 1'b1);
                    h1_reg      <= bfdh_pkg::fnv_fold(h1_reg, in_word.key_byte);
                end
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg <= in_word.opcode;
            if (in_word.key_last && ovf_now)
            begin
                pres_reg <= 1'b1;
                ovfr_reg <= 1'b1;
            end
        end
        if (cmd.load)
        begin
            h2_reg     <= bfdh_pkg::FNV_BASIS ^ h1_reg;
            nb_reg     <= nb_eff;
            k_reg      <= k_eff;
            fcnt_reg   <= '0;
            rd_ptr_reg <= LEN_W'(1);
            pres_reg   <= 1'b1;
            ovfr_reg   <= 1'b0;
        end
        if (cmd.pass)
        begin
            h2_reg     <= bfdh_pkg::fnv_fold(h2_reg, key_q_reg);
            fcnt_reg   <= LEN_W'(fcnt_reg + 1'b1);
            rd_ptr_reg <= LEN_W'(rd_ptr_reg + 1'b1);
        end
        if (cmd.minit)
        begin
            sh1_reg     <= {1'b0, h1_reg};
            sh2_reg     <= {1'b0, h2_reg};
            r1_reg      <= '0;
            r2_reg      <= '0;
            rw_reg      <= '0;
            mod_cnt_reg <= '0;
            acc_reg     <= h1_reg;
            idx_cnt_reg <= '0;
        end
        if (cmd.mod)
        begin
            // Three lanes: h1, h2 and 2^64, one dividend bit per cycle
            r1_reg      <= mod_step(r1_reg, sh1_reg[64], nb_reg);
            r2_reg      <= mod_step(r2_reg, sh2_reg[64], nb_reg);
            rw_reg      <= mod_step(rw_reg, (mod_cnt_reg == '0), nb_reg);
            sh1_reg     <= sh1_reg << 1;
            sh2_reg     <= sh2_reg << 1;
            mod_cnt_reg <= 7'(mod_cnt_reg + 1'b1);
        end
        if (cmd.idx_rd)
        begin
            acc_reg <= acc_sum[63:0];
            cy_reg  <= acc_sum[64];
        end
        if (cmd.idx_wr)
        begin
            r1_reg      <= r_step;
            idx_cnt_reg <= HW'(idx_cnt_reg + 1'b1);
            if (op_reg && !bit_hit)
            begin
                pres_reg <= 1'b0;
            end
        end
    end

    // Key buffer
    always_ff @(posedge clk)
    begin
        if (cmd.take && !ovf_now)
        begin
            key_mem[key_len_reg[KA_W-1:0]] <= in_word.key_byte;
        end
        key_q_reg <= key_mem[key_rd_addr];
    end

    // Filter bit store, one byte per word
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            filt_mem[clr_ptr_reg] <= 8'd0;
        end
        else if (cmd.idx_wr && (op_reg == bfdh_pkg::OP_ADD))
        begin
            filt_mem[f_addr] <= filt_q_reg | bit_mask;
        end
        filt_q_reg <= filt_mem[f_addr];
    end

endmodule

`default_nettype wire

### hdl/bloom_filter_fnv1a_double_hash_core.sv
`default_nettype none

// Bloom filter with FNV-1a double hashing. Keys come in one byte per start
// pulse; a byte without key_last is taken while busy stays low. The byte
// with key_last raises busy while the block rehashes the key from its
// buffer byte by byte, reduces h1, h2 and 2^64 modulo the bit count in a
// bit-serial unit and then visits each derived index with a
// read-modify-write of the filter memory, a read state then a write state.
// A query stops early when it meets a clear bit. An overflowed key answers
// in the cycle after its last byte is taken. The result is shown on result
// for exactly one cycle with done high; there is no way to hold it, so
// sample it then. After reset the filter memory is cleared one byte a cycle,
// all (MAX_BITS+7)/8 bytes (8192 at the default size), with busy high;
// configuration writes are taken at any time but should be made only while
// busy is low.
module bloom_filter_fnv1a_double_hash_core #(
    parameter int MAX_BITS      = bfdh_pkg::DEF_MAX_BITS,
    parameter int MAX_KEY_BYTES = bfdh_pkg::DEF_MAX_KEY_BYTES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire bfdh_pkg::in_word_t              in_word,
    output logic                                 done,
    output bfdh_pkg::out_word_t                  result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data
);

    bfdh_pkg::cmd_t    cmd;
    bfdh_pkg::status_t status;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    bfdh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key_last (in_word.key_last),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    bfdh_dp #(
        .MAX_BITS      (MAX_BITS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // A result only appears while the block is busy with a key end
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Each result word is a single-cycle strobe
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // A byte that does not end a key produces no word
    a_mid_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !in_word.key_last) |=> !done)
        else $error("result after a middle key byte");

    // An overflowed key always reports maybe_present
    a_ovf_present: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.key_overflow) |-> result.maybe_present)
        else $error("overflow result without maybe_present");

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts the filter's answer for every key end and checks results in order
    class bloom_scoreboard;
        bit                      filter_mem [65536];
        logic [7:0]              key_buf [64];
        int unsigned             key_len;
        bit                      key_ovf;
        logic [63:0]             fold_h1;
        logic [16:0]             bit_count;
        logic [4:0]              hash_count;
        bfdh_pkg::out_word_t     answers_due [$];
        int                      errors;
        int                      key_ends;
        int                      overflows;
        int                      hits;

        function new();
            foreach (filter_mem[i]) filter_mem[i] = 1'b0;
            key_len = 0;
            key_ovf = 1'b0;
            fold_h1 = bfdh_pkg::FNV_BASIS;
            bit_count = bfdh_pkg::BIT_COUNT_RST;
            hash_count = bfdh_pkg::HASH_COUNT_RST;
            errors = 0;
            key_ends = 0;
            overflows = 0;
            hits = 0;
        endfunction

        function logic [63:0] fnv_round(logic [63:0] h, logic [7:0] b);
            return (h ^ {56'd0, b}) * 64'd1099511628211;
        endfunction

        function void write_reg(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                                logic [bfdh_pkg::CFG_DATA_W-1:0] v);
            if (idx == bfdh_pkg::CFG_BIT_COUNT) bit_count = v;
            else if (idx == bfdh_pkg::CFG_HASH_COUNT) hash_count = v[bfdh_pkg::HASH_W-1:0];
        endfunction

        // Fold one accepted byte; at a key end work out the answer
        function void note_word(bfdh_pkg::in_word_t w);
            logic [63:0] h2;
            logic [63:0] nb;
            logic [63:0] slot;
            int unsigned nk;
            bfdh_pkg::out_word_t ans;
            if (key_len >= 64) key_ovf = 1'b1;
            else
            begin
                key_buf[key_len] = w.key_byte;
                key_len++;
                fold_h1 = fnv_round(fold_h1, w.key_byte);
            end
            if (!w.key_last) return;
            key_ends++;
            if (key_ovf)
            begin
                ans.maybe_present = 1'b1;
                ans.key_overflow = 1'b1;
                overflows++;
            end
            else
            begin
                h2 = bfdh_pkg::FNV_BASIS ^ fold_h1;
                for (int p = 0; p < key_len; p++) h2 = fnv_round(h2, key_buf[p]);
                nb = (bit_count < 8) ? 64'd8 : (bit_count > 65536) ? 64'd65536 : 64'(bit_count);
                nk = (hash_count == 0) ? 1 : (hash_count > 30) ? 30 : hash_count;
                ans.maybe_present = 1'b1;
                ans.key_overflow = 1'b0;
                for (int i = 0; i < nk; i++)
                begin
                    slot = (fold_h1 + 64'(i) * h2) % nb;
                    if (w.opcode == bfdh_pkg::OP_ADD) filter_mem[slot] = 1'b1;
                    else if (!filter_mem[slot])
                    begin
                        ans.maybe_present = 1'b0;
                        break;
                    end
                end
                if (w.opcode == bfdh_pkg::OP_QUERY && ans.maybe_present) hits++;
            end
            answers_due.push_back(ans);
            key_len = 0;
            key_ovf = 1'b0;
            fold_h1 = bfdh_pkg::FNV_BASIS;
        endfunction

        function void check_result(bfdh_pkg::out_word_t r);
            bfdh_pkg::out_word_t e;
            if (answers_due.size() == 0)
            begin
                $error("result with nothing expected: maybe_present=%0b key_overflow=%0b",
                       r.maybe_present, r.key_overflow);
                errors++;
                return;
            end
            e = answers_due.pop_front();
            if (r.maybe_present !== e.maybe_present)
            begin
                $error("maybe_present: expected %0b, got %0b", e.maybe_present, r.maybe_present);
                errors++;
            end
            if (r.key_overflow !== e.key_overflow)
            begin
                $error("key_overflow: expected %0b, got %0b", e.key_overflow, r.key_overflow);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    bfdh_pkg::in_word_t              in_word;
    logic                            done;
    bfdh_pkg::out_word_t             result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data;

    bloom_scoreboard sb;
    int unsigned     cycles;
    int              words_sent;
    bit              no_gaps;

    // Keys kept for later queries so that hits occur
    logic [7:0]  kept_key [16][64];
    int          kept_len [16];
    int          kept_cnt;

    bloom_filter_fnv1a_double_hash_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Results cannot be held off: sample on every edge where done is high
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(result);
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1500000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none during a burst
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold start until the block takes the word, then note it in the scoreboard
    task automatic send_word(bfdh_pkg::in_word_t w);
        int gap;
        start <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (busy);
        sb.note_word(w);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            in_word <= bfdh_pkg::in_word_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drive a whole key; non-final bytes carry a random opcode unless asked not to
    task automatic send_key(bfdh_pkg::opcode_t op, logic [7:0] kb [$], bit steady_op);
        bfdh_pkg::in_word_t w;
        for (int i = 0; i < kb.size(); i++)
        begin
            w.key_byte = kb[i];
            w.key_last = (i == kb.size() - 1);
            w.opcode = (w.key_last || steady_op) ? op
                                                 : bfdh_pkg::opcode_t'($urandom_range(0, 1));
            send_word(w);
        end
    endtask

    task automatic random_key(output logic [7:0] kb [$], input int len);
        kb.delete();
        for (int i = 0; i < len; i++) kb.push_back(8'($urandom));
    endtask

    task automatic keep_key(logic [7:0] kb [$]);
        int slot;
        if (kb.size() > 64) return;
        slot = (kept_cnt < 16) ? kept_cnt : $urandom_range(0, 15);
        if (kept_cnt < 16) kept_cnt++;
        for (int i = 0; i < kb.size(); i++) kept_key[slot][i] = kb[i];
        kept_len[slot] = kb.size();
    endtask

    // Drain: drop start, wait until nothing is pending and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.answers_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then drop valid again
    task automatic write_reg(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                             logic [bfdh_pkg::CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] kb [$];
        int len;
        int r;
        int pick;
        logic [16:0] bit_opts [8];
        logic [4:0]  hash_opts [8];

        sb = new();
        words_sent = 0;
        kept_cnt = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // Let the power-on clearing pass finish
        @(posedge clk);
        while (busy) @(posedge clk);

        // Directed: one-byte extremes, hit and miss, full-length key,
        // overflowed key, opcode flipping inside a key
        kb = '{8'h00};
        send_key(bfdh_pkg::OP_ADD, kb, 1'b1);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        kb = '{8'hFF};
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        send_key(bfdh_pkg::OP_ADD, kb, 1'b1);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        random_key(kb, 64);
        send_key(bfdh_pkg::OP_ADD, kb, 1'b0);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b0);
        random_key(kb, 66);
        send_key(bfdh_pkg::OP_ADD, kb, 1'b1);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        wait_idle();

        // Out-of-range and unknown register writes, then extremes
        write_reg(2'd2, 17'h1FFFF);
        write_reg(2'd3, 17'h00000);
        write_reg(bfdh_pkg::CFG_BIT_COUNT, 17'd0);
        write_reg(bfdh_pkg::CFG_HASH_COUNT, 17'd0);
        kb = '{8'h5A, 8'hA5};
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        send_key(bfdh_pkg::OP_ADD, kb, 1'b1);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        wait_idle();
        write_reg(bfdh_pkg::CFG_BIT_COUNT, 17'h1FFFF);
        write_reg(bfdh_pkg::CFG_HASH_COUNT, 17'd31);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        send_key(bfdh_pkg::OP_ADD, kb, 1'b1);
        send_key(bfdh_pkg::OP_QUERY, kb, 1'b1);
        wait_idle();

        bit_opts  = '{17'd65536, 17'd8, 17'd7, 17'd131071, 17'd1000, 17'd65535,
                      17'd4096, 17'd333};
        hash_opts = '{5'd7, 5'd1, 5'd30, 5'd31, 5'd0, 5'd3, 5'd12, 5'd20};

        // Random phases, each under its own register setting
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(bfdh_pkg::CFG_BIT_COUNT, bit_opts[phase]);
            write_reg(bfdh_pkg::CFG_HASH_COUNT, hash_opts[phase]);
            while (words_sent < 280 + (phase + 1) * 145)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 6)
                    len = $urandom_range(65, 70);
                else if (r < 14)
                    len = $urandom_range(40, 64);
                else
                    len = $urandom_range(1, 8);
                r = $urandom_range(0, 99);
                if (r < 40 && kept_cnt > 0)
                begin
                    // Ask about a key added earlier
                    pick = $urandom_range(0, kept_cnt - 1);
                    kb.delete();
                    for (int i = 0; i < kept_len[pick]; i++) kb.push_back(kept_key[pick][i]);
                    send_key(bfdh_pkg::OP_QUERY, kb, 1'b0);
                end
                else
                begin
                    random_key(kb, len);
                    if (r < 75)
                    begin
                        send_key(bfdh_pkg::OP_ADD, kb, 1'b0);
                        keep_key(kb);
                    end
                    else
                        send_key(bfdh_pkg::OP_QUERY, kb, 1'b0);
                end
            end
            no_gaps = 1'b0;
            wait_idle();
        end

        // Trailing margin for any late result
        repeat (200) @(posedge clk);
        if (sb.answers_due.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.answers_due.size());
            sb.errors++;
        end
        $display("covered %0d key bytes, %0d key ends (%0d overflowed, %0d query hits)",
                 words_sent, sb.key_ends, sb.overflows, sb.hits);
        $display("register settings swept from 8 to 65536 bits and 1 to 30 hashes");
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### bloom_filter_fnv1a_double_hash_core.f
hdl/bfdh_pkg.sv
hdl/bfdh_ctrl.sv
hdl/bfdh_dp.sv
hdl/bloom_filter_fnv1a_double_hash_core.sv
tb/testbench.sv
